@@ hdl/nearest_waypoint_search_unit_macros.svh @@
// Assertion macros shared by the nearest waypoint search RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef NEAREST_WAYPOINT_SEARCH_UNIT_MACROS_SVH
`define NEAREST_WAYPOINT_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define NWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define NWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/nws_pkg.sv @@
// Shared types and constants of the nearest waypoint search unit.
// Depends on nothing; used by the distance unit, the tracker and the top level.
package nws_pkg;

	localparam int COORD_W = 32;
	localparam int MAG_W   = 32;
	localparam int SQ_W    = 64;
	localparam int DIST_W  = 65;
	localparam int KIND_W  = 2;
	localparam int OUT_IDX_W = 10;

	localparam logic [KIND_W-1:0] KIND_NEW_LANE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd2;

	// Control of the shared distance unit
	typedef struct packed {
		logic load_mag;  // capture fresh coordinate magnitudes
		logic phase_y;   // multiplier works on y this cycle
	} dist_ctrl_t;

	// Control of the best-candidate tracker
	typedef struct packed {
		logic en;     // a finished distance is present
		logic first;  // first waypoint of the scan
	} cmp_ctrl_t;

endpackage

@@ hdl/nws_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module nws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/nws_dist_unit.sv @@
// Squared distance unit: coordinate magnitudes, one shared 32x32 multiplier
// used for x then y, and the final 65-bit sum. Depends on nws_pkg.
module nws_dist_unit (
	input  logic                               clk,
	input  nws_pkg::dist_ctrl_t                ctrl,
	input  logic signed [nws_pkg::COORD_W-1:0] px,
	input  logic signed [nws_pkg::COORD_W-1:0] py,
	input  logic signed [nws_pkg::COORD_W-1:0] wx,
	input  logic signed [nws_pkg::COORD_W-1:0] wy,
	output logic [nws_pkg::DIST_W-1:0]         sq_sum
);

	logic signed [nws_pkg::COORD_W:0] dx, dy;
	logic [nws_pkg::COORD_W:0]        ndx, ndy;
	logic [nws_pkg::MAG_W-1:0]        mag_x, mag_y;
	logic [nws_pkg::MAG_W-1:0]        mag_x_s2, mag_y_s2;
	logic [nws_pkg::MAG_W-1:0]        mul_op;
	logic [nws_pkg::SQ_W-1:0]         prod_s3;
	logic [nws_pkg::SQ_W-1:0]         sqx_s4;

	// Form absolute differences; they always fit 32 bits unsigned
	always_comb begin
		dx    = {px[nws_pkg::COORD_W-1], px} - {wx[nws_pkg::COORD_W-1], wx};
		dy    = {py[nws_pkg::COORD_W-1], py} - {wy[nws_pkg::COORD_W-1], wy};
		ndx   = -dx;
		ndy   = -dy;
		mag_x = dx[nws_pkg::COORD_W] ? ndx[nws_pkg::MAG_W-1:0] : dx[nws_pkg::MAG_W-1:0];
		mag_y = dy[nws_pkg::COORD_W] ? ndy[nws_pkg::MAG_W-1:0] : dy[nws_pkg::MAG_W-1:0];
	end

	// Hold the magnitudes for both multiplier passes
	always_ff @(posedge clk) begin
		if (ctrl.load_mag) begin
			mag_x_s2 <= mag_x;
			mag_y_s2 <= mag_y;
		end
	end

	// Shared multiplier: x on the first pass, y on the second
	assign mul_op = ctrl.phase_y ? mag_y_s2 : mag_x_s2;

	always_ff @(posedge clk) begin
		prod_s3 <= nws_pkg::SQ_W'(mul_op) * nws_pkg::SQ_W'(mul_op);
	end

	// Park the x square while y is squared
	always_ff @(posedge clk) begin
		if (ctrl.phase_y) begin
			sqx_s4 <= prod_s3;
		end
	end

	// Exact sum with carry bit
	assign sq_sum = {1'b0, sqx_s4} + {1'b0, prod_s3};

endmodule

@@ hdl/nws_best.sv @@
// Best-candidate tracker: keeps the smallest distance seen in a scan and
// its index; ties keep the earlier index. Depends on nws_pkg.
module nws_best #(
	parameter int IDX_W = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nws_pkg::cmp_ctrl_t         ctrl,
	input  logic [nws_pkg::DIST_W-1:0] sq_sum,
	input  logic [IDX_W-1:0]           idx,
	output logic [IDX_W-1:0]           win_idx
);

	logic [nws_pkg::DIST_W-1:0] best_q;
	logic [IDX_W-1:0]           best_idx_q;
	logic                       take;

	// Strictly smaller wins, so ties stay with the lower index
	assign take    = ctrl.first || (sq_sum < best_q);
	assign win_idx = take ? idx : best_idx_q;

	// Hold the running minimum
	always_ff @(posedge clk) begin
		if (ctrl.en && take) begin
			best_q <= sq_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_idx_q <= '0;
		end else if (ctrl.en && take) begin
			best_idx_q <= idx;
		end
	end

endmodule

@@ hdl/nearest_waypoint_search_unit.sv @@
// Top level of the nearest waypoint search unit: command port, waypoint
// tables, scan sequencer. Depends on nws_pkg, nws_ram, nws_dist_unit, nws_best.
//
// Channel   Ports                               Transfer
// command   start, busy, kind, pos_x, pos_y     start && !busy at clk rise
// result    done, nearest_idx                   done high for one cycle
//
// Loads (new lane, append) and unused kinds leave busy low.
// A query against N stored waypoints holds busy while the single shared
// multiplier squares x and then y of each waypoint; reads of later waypoints
// overlap the sums of earlier ones. done pulses in the same cycle that busy falls.
// A query against an empty table gives no done and no busy.
// Reset clears the waypoint count and the sequencer; tables are not cleared.
module nearest_waypoint_search_unit #(
	parameter int MAX_WAYPOINTS = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [nws_pkg::KIND_W-1:0]         kind,
	input  logic signed [nws_pkg::COORD_W-1:0] pos_x,
	input  logic signed [nws_pkg::COORD_W-1:0] pos_y,
	output logic                               done,
	output logic [nws_pkg::OUT_IDX_W-1:0]      nearest_idx
);

	`include "nearest_waypoint_search_unit_macros.svh"

	localparam int IDX_W = $clog2(MAX_WAYPOINTS);
	localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t                            state_q;
	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  iss_q;
	logic [IDX_W-1:0]                  cmp_idx_q;
	logic                              ph_q;
	logic                              rd_v_s1, mv_s2, pv_s3;
	logic signed [nws_pkg::COORD_W-1:0] px_q, py_q;
	logic                              done_q;
	logic [nws_pkg::OUT_IDX_W-1:0]     closest_q;

	logic                              accept;
	logic                              wr_en;
	logic [IDX_W-1:0]                  wr_addr;
	logic                              issue;
	logic                              last_cmp;
	logic [nws_pkg::COORD_W-1:0]       wx_raw, wy_raw;
	logic [nws_pkg::DIST_W-1:0]        sq_sum;
	logic [IDX_W-1:0]                  win_idx;
	nws_pkg::dist_ctrl_t               dctrl;
	nws_pkg::cmp_ctrl_t                cctrl;

	assign busy        = (state_q == ST_SCAN);
	assign done        = done_q;
	assign nearest_idx = closest_q;
	assign accept      = start && !busy;

	// Table writes: a new lane lands at entry 0, an append at the count
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		case (kind)
			nws_pkg::KIND_NEW_LANE: begin
				wr_en   = accept;
				wr_addr = '0;
			end
			nws_pkg::KIND_APPEND: begin
				wr_en = accept && (count_q < CNT_W'(MAX_WAYPOINTS));
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Issue reads and compare only on the even phase
	assign issue    = busy && !ph_q && (iss_q < count_q);
	assign last_cmp = cctrl.en && (CNT_W'(cmp_idx_q) == count_q - CNT_W'(1));

	assign dctrl.load_mag = busy && ph_q;
	assign dctrl.phase_y  = ph_q;
	assign cctrl.en       = busy && !ph_q && pv_s3;
	assign cctrl.first    = (cmp_idx_q == '0);

	nws_ram #(
		.WIDTH (nws_pkg::COORD_W),
		.DEPTH (MAX_WAYPOINTS)
	) u_ram_x (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (pos_x),
		.re    (issue),
		.raddr (iss_q[IDX_W-1:0]),
		.rdata (wx_raw)
	);

	nws_ram #(
		.WIDTH (nws_pkg::COORD_W),
		.DEPTH (MAX_WAYPOINTS)
	) u_ram_y (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (pos_y),
		.re    (issue),
		.raddr (iss_q[IDX_W-1:0]),
		.rdata (wy_raw)
	);

	nws_dist_unit u_dist (
		.clk    (clk),
		.ctrl   (dctrl),
		.px     (px_q),
		.py     (py_q),
		.wx     (signed'(wx_raw)),
		.wy     (signed'(wy_raw)),
		.sq_sum (sq_sum)
	);

	nws_best #(
		.IDX_W (IDX_W)
	) u_best (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (cctrl),
		.sq_sum  (sq_sum),
		.idx     (cmp_idx_q),
		.win_idx (win_idx)
	);

	// Latch the query pose
	always_ff @(posedge clk) begin
		if (accept && kind == nws_pkg::KIND_QUERY) begin
			px_q <= pos_x;
			py_q <= pos_y;
		end
	end

	// Hold the result index for its strobe
	always_ff @(posedge clk) begin
		if (last_cmp) begin
			closest_q <= nws_pkg::OUT_IDX_W'(win_idx);
		end
	end

	// Sequencer, counters and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			iss_q     <= '0;
			cmp_idx_q <= '0;
			ph_q      <= 1'b0;
			rd_v_s1   <= 1'b0;
			mv_s2     <= 1'b0;
			pv_s3     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (kind)
							nws_pkg::KIND_NEW_LANE: begin
								count_q <= CNT_W'(1);
							end
							nws_pkg::KIND_APPEND: begin
								if (count_q < CNT_W'(MAX_WAYPOINTS)) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							nws_pkg::KIND_QUERY: begin
								if (count_q != '0) begin
									state_q   <= ST_SCAN;
									iss_q     <= '0;
									cmp_idx_q <= '0;
									ph_q      <= 1'b0;
									rd_v_s1   <= 1'b0;
									mv_s2     <= 1'b0;
									pv_s3     <= 1'b0;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					ph_q <= !ph_q;
					if (!ph_q) begin
						rd_v_s1 <= issue;
						if (issue) begin
							iss_q <= iss_q + CNT_W'(1);
						end
					end else begin
						mv_s2 <= rd_v_s1;
						pv_s3 <= mv_s2;
					end
					if (cctrl.en) begin
						cmp_idx_q <= cmp_idx_q + IDX_W'(1);
					end
					if (last_cmp) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`NWS_ASSERT_NXT(a_done_single, clk, arst_n, done_q, !done_q, "result strobe longer than one cycle")
	`NWS_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, !busy, "result strobe while scan still busy")
	`NWS_ASSERT_NXT(a_query_starts, clk, arst_n, accept && kind == nws_pkg::KIND_QUERY && count_q != '0, busy, "query on a filled table did not start a scan")
	`NWS_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_WAYPOINTS), "waypoint count beyond table depth")
	`NWS_ASSERT_IMP(a_issue_bound, clk, arst_n, busy, iss_q <= count_q && count_q != '0, "scan read past the waypoint count")

endmodule
